// File: rtl/core/wsg_pkg.sv
// Shared types, codes and constants for the waveform sample generator.
package wsg_pkg;

  // Waveform select codes carried in the cmd field.
  localparam logic [1:0] CMD_TRI   = 2'd0;
  localparam logic [1:0] CMD_SINE  = 2'd1;
  localparam logic [1:0] CMD_NOISE = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Shortest usable cycle lengths for the periodic waves.
  localparam logic [7:0] TRI_MIN_CYCLE  = 8'd4;
  localparam logic [7:0] SINE_MIN_CYCLE = 8'd2;

  // Noise generator constants.
  localparam logic [31:0] NOISE_SEED    = 32'h1234_5678;
  localparam int          NOISE_SHIFT_A = 13;
  localparam int          NOISE_SHIFT_B = 17;
  localparam int          NOISE_SHIFT_C = 5;
  localparam logic [7:0]  NOISE_SCALE   = 8'd127;

  // Sine shaping: x runs over 256 steps centered on 128, x*x*A is scaled by 2^14.
  localparam logic signed [9:0] SINE_CENTER = 10'sd128;
  localparam int                SINE_SHIFT  = 14;

  // Divider geometry.
  localparam int DIV_W   = 16;
  localparam int DVS_W   = 8;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Region codes kept after the phase is known.
  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_FALL = 2'd1;
  localparam logic [1:0] SEG_TAIL = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] position;
    logic [7:0] cycle_length;
    logic [6:0] amplitude;
  } wsg_in_t;

  typedef struct packed {
    logic signed [7:0] sample;
    logic bad_cycle;
  } wsg_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MOD_WAIT,
    ST_NOISE,
    ST_PREP,
    ST_WAVE_START,
    ST_WAVE_WAIT,
    ST_SQUARE,
    ST_SCALE,
    ST_OUT
  } wsg_state_t;

  typedef enum logic {
    DIV_MOD,
    DIV_WAVE
  } wsg_div_sel_t;

  typedef struct packed {
    logic         load;
    logic         div_start;
    wsg_div_sel_t div_sel;
    logic         cap_mod;
    logic         noise_step;
    logic         prep;
    logic         cap_quo;
    logic         square;
    logic         scale;
    logic         out_load;
  } wsg_ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad;
    logic       div_done;
    logic       out_free;
  } wsg_status_t;

endpackage

// File: rtl/core/waveform_sample_generator_top.sv
// Requests are taken one at a time and in order: a new request is accepted only after the
// previous one has been sequenced into the result register.
// Periodic waves wait twice on the shared one-bit-per-cycle divider: one division
// for the phase (position modulo cycle length), one for the wave value. Noise skips it.
// Reset (rst, synchronous, active high) idles the sequencer, empties the result register
// and reloads the noise register with its seed.
module waveform_sample_generator_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wsg_pkg::wsg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wsg_pkg::wsg_out_t out_data
);

  // Commands from the sequencer and the status it steers by.
  wsg_pkg::wsg_ctrl_t   ctrl;
  wsg_pkg::wsg_status_t status;

  // The sequencer takes one request at a time. It may take the next request while the
  // previous result still waits in the output register, and only holds in its final
  // state when that register is still full and stalled.
  wsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  // The datapath holds the request, the divider, the small multipliers, the noise
  // register and the result register.
  wsg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/wsg_divider.sv
// Radix-2 restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
module wsg_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wsg_pkg::DIV_W-1:0]   dividend,
  input  logic [wsg_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [wsg_pkg::DIV_W-1:0]   quotient,
  output logic [wsg_pkg::DVS_W-1:0]   remainder
);

  logic                          busy;
  logic [wsg_pkg::DIV_CNT_W-1:0] cnt;
  logic [wsg_pkg::DIV_W-1:0]     quo;
  logic [wsg_pkg::DVS_W-1:0]     rem;
  logic [wsg_pkg::DVS_W-1:0]     dvs;
  logic [wsg_pkg::DVS_W:0]       trial;
  logic                          ge;
  logic [wsg_pkg::DVS_W-1:0]     rem_next;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    trial    = {rem, quo[wsg_pkg::DIV_W-1]};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? wsg_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[wsg_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[wsg_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == wsg_pkg::DIV_CNT_W'(wsg_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/core/wsg_datapath.sv
// Datapath: request registers, phase and wave arithmetic, noise register, result register.
module wsg_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  wsg_pkg::wsg_in_t     in_data,
  input  wsg_pkg::wsg_ctrl_t   ctrl,
  output wsg_pkg::wsg_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsg_pkg::wsg_out_t    out_data
);

  logic [1:0]  cmd_r;
  logic [15:0] pos_r;
  logic [7:0]  cl_r;
  logic [6:0]  amp_r;
  logic        bad_r;
  logic [7:0]  p_r;
  logic [1:0]  seg_r;
  logic [15:0] num_r;
  logic [7:0]  den_r;
  logic [8:0]  quo_r;
  logic [14:0] sq_r;
  logic [20:0] prod_r;
  logic [31:0] noise_state;

  logic                        div_start;
  logic [wsg_pkg::DIV_W-1:0]   div_dividend;
  logic [wsg_pkg::DVS_W-1:0]   div_divisor;
  logic                        div_done;
  logic [wsg_pkg::DIV_W-1:0]   div_quotient;
  logic [wsg_pkg::DVS_W-1:0]   div_remainder;

  logic [31:0] ns1, ns2, ns3;
  logic [7:0]  q_len, h_len, q3_len;
  logic [7:0]  base, mag, mul_in;
  logic [15:0] mul_out;
  logic [15:0] noise_sum;
  logic [8:0]  noise_quo;
  logic [1:0]  seg_next;
  logic [15:0] num_next;
  logic [7:0]  den_next;
  logic signed [9:0]  x;
  logic signed [19:0] sq_full;
  logic [7:0]  amp8, q8, sine_v, sample_next;
  logic        bad_next;

  assign div_start    = ctrl.div_start;
  assign div_dividend = (ctrl.div_sel == wsg_pkg::DIV_MOD) ? pos_r : num_r;
  assign div_divisor  = (ctrl.div_sel == wsg_pkg::DIV_MOD) ? cl_r : den_r;

  wsg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Xorshift step of the noise register.
  always_comb begin
    ns1 = noise_state ^ (noise_state << wsg_pkg::NOISE_SHIFT_A);
    ns2 = ns1 ^ (ns1 >> wsg_pkg::NOISE_SHIFT_B);
    ns3 = ns2 ^ (ns2 << wsg_pkg::NOISE_SHIFT_C);
  end

  assign bad_next = ((in_data.cmd == wsg_pkg::CMD_TRI) &&
                     (in_data.cycle_length < wsg_pkg::TRI_MIN_CYCLE)) ||
                    ((in_data.cmd == wsg_pkg::CMD_SINE) &&
                     (in_data.cycle_length < wsg_pkg::SINE_MIN_CYCLE));

  // Pick the segment, the dividend and the divisor of the wave division.
  always_comb begin
    q_len  = {2'b00, cl_r[7:2]};
    h_len  = {1'b0, cl_r[7:1]};
    q3_len = q_len + {q_len[6:0], 1'b0};
    mag    = noise_state[7] ? 8'(-noise_state[7:0]) : noise_state[7:0];
    base     = p_r;
    seg_next = wsg_pkg::SEG_RISE;
    if (cmd_r == wsg_pkg::CMD_SINE) begin
      if (p_r >= h_len) begin
        base     = p_r - h_len;
        seg_next = wsg_pkg::SEG_FALL;
      end
    end else if (p_r >= q3_len) begin
      base     = p_r - q3_len;
      seg_next = wsg_pkg::SEG_TAIL;
    end else if (p_r >= q_len) begin
      base     = p_r - q_len;
      seg_next = wsg_pkg::SEG_FALL;
    end
    mul_in  = (cmd_r == wsg_pkg::CMD_NOISE) ? mag : base;
    mul_out = {8'b0, mul_in} * {9'b0, amp_r};
    case (cmd_r)
      wsg_pkg::CMD_TRI: begin
        num_next = mul_out;
        den_next = q_len;
      end
      wsg_pkg::CMD_SINE: begin
        num_next = {base, 8'h00};
        den_next = h_len;
      end
      wsg_pkg::CMD_NOISE: begin
        num_next = mul_out;
        den_next = wsg_pkg::NOISE_SCALE;
        seg_next = {1'b0, noise_state[7]};
      end
      default: begin
        num_next = '0;
        den_next = wsg_pkg::NOISE_SCALE;
      end
    endcase
  end

  // Noise magnitude divided by 127: for products up to 128*127, (v + v/128 + 1)/128 is exact.
  assign noise_sum = mul_out + {7'b0, mul_out[15:7]} + 16'd1;
  assign noise_quo = noise_sum[15:7];

  assign x       = $signed({1'b0, quo_r}) - wsg_pkg::SINE_CENTER;
  assign sq_full = x * x;

  // Final value, kept to its low eight bits.
  always_comb begin
    amp8   = {1'b0, amp_r};
    q8     = quo_r[7:0];
    sine_v = amp8 - {1'b0, prod_r[wsg_pkg::SINE_SHIFT +: 7]};
    case (cmd_r)
      wsg_pkg::CMD_TRI: begin
        case (seg_r)
          wsg_pkg::SEG_RISE: sample_next = q8;
          wsg_pkg::SEG_FALL: sample_next = amp8 - q8;
          default:           sample_next = q8 - amp8;
        endcase
      end
      wsg_pkg::CMD_SINE:  sample_next = (seg_r == wsg_pkg::SEG_FALL) ? 8'(-sine_v) : sine_v;
      wsg_pkg::CMD_NOISE: sample_next = seg_r[0] ? 8'(-q8) : q8;
      default:            sample_next = '0;
    endcase
    if (bad_r) begin
      sample_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_data.cmd;
      pos_r <= in_data.position;
      cl_r  <= in_data.cycle_length;
      amp_r <= in_data.amplitude;
      bad_r <= bad_next;
    end
    if (ctrl.cap_mod) begin
      p_r <= div_remainder;
    end
    if (ctrl.prep) begin
      seg_r <= seg_next;
      num_r <= num_next;
      den_r <= den_next;
    end
    if (ctrl.cap_quo) begin
      quo_r <= (cmd_r == wsg_pkg::CMD_NOISE) ? noise_quo : div_quotient[8:0];
    end
    if (ctrl.square) begin
      sq_r <= sq_full[14:0];
    end
    if (ctrl.scale) begin
      prod_r <= {6'b0, sq_r} * {14'b0, amp_r};
    end
    if (ctrl.out_load) begin
      out_data.sample    <= sample_next;
      out_data.bad_cycle <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_state <= wsg_pkg::NOISE_SEED;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.noise_step) begin
        noise_state <= ns3;
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.cmd      = cmd_r;
  assign status.bad      = bad_r;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: rtl/core/wsg_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module wsg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wsg_pkg::wsg_status_t status,
  output wsg_pkg::wsg_ctrl_t   ctrl
);

  wsg_pkg::wsg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.div_sel = wsg_pkg::DIV_MOD;
    in_stall   = 1'b1;
    case (state)
      wsg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = wsg_pkg::ST_DECIDE;
        end
      end
      wsg_pkg::ST_DECIDE: begin
        if (status.bad || (status.cmd == wsg_pkg::CMD_NONE)) begin
          state_next = wsg_pkg::ST_OUT;
        end else if (status.cmd == wsg_pkg::CMD_NOISE) begin
          state_next = wsg_pkg::ST_NOISE;
        end else begin
          ctrl.div_start = 1'b1;
          state_next     = wsg_pkg::ST_MOD_WAIT;
        end
      end
      wsg_pkg::ST_MOD_WAIT: begin
        if (status.div_done) begin
          ctrl.cap_mod = 1'b1;
          state_next   = wsg_pkg::ST_PREP;
        end
      end
      wsg_pkg::ST_NOISE: begin
        ctrl.noise_step = 1'b1;
        state_next      = wsg_pkg::ST_PREP;
      end
      wsg_pkg::ST_PREP: begin
        ctrl.prep = 1'b1;
        if (status.cmd == wsg_pkg::CMD_NOISE) begin
          ctrl.cap_quo = 1'b1;
          state_next   = wsg_pkg::ST_OUT;
        end else begin
          state_next = wsg_pkg::ST_WAVE_START;
        end
      end
      wsg_pkg::ST_WAVE_START: begin
        ctrl.div_start = 1'b1;
        ctrl.div_sel   = wsg_pkg::DIV_WAVE;
        state_next     = wsg_pkg::ST_WAVE_WAIT;
      end
      wsg_pkg::ST_WAVE_WAIT: begin
        if (status.div_done) begin
          ctrl.cap_quo = 1'b1;
          state_next   = (status.cmd == wsg_pkg::CMD_SINE) ? wsg_pkg::ST_SQUARE
                                                           : wsg_pkg::ST_OUT;
        end
      end
      wsg_pkg::ST_SQUARE: begin
        ctrl.square = 1'b1;
        state_next  = wsg_pkg::ST_SCALE;
      end
      wsg_pkg::ST_SCALE: begin
        ctrl.scale = 1'b1;
        state_next = wsg_pkg::ST_OUT;
      end
      wsg_pkg::ST_OUT: begin
        if (status.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = wsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wsg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/wsg_checker.sv
// Port-level checks for the waveform sample generator, bound to the top level.
module wsg_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input wsg_pkg::wsg_out_t out_data
);

  // A result held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // A flagged request always yields a zero sample.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_cycle |-> out_data.sample == 8'sd0)
    else $error("flagged result carries a nonzero sample");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A result never appears in the cycle after its request was taken.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind waveform_sample_generator_top wsg_checker u_wsg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
